@@ rtl/tma_pkg.sv @@
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types, widths and helpers for the trajectory metric accumulator.
// ----------------------------------------------------------------------------
package tma_pkg;

  // fixed point layout
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int TOTAL_WIDTH = 48;
  // product accumulator: sum of three 32x32 squares
  localparam int PROD_W      = 2 * DATA_W + 2;
  // serial unit step counts
  localparam int MUL_STEPS   = DATA_W + 1;
  localparam int DIV_STEPS   = DATA_W + FRAC_BITS;
  localparam int ROOT_STEPS  = (PROD_W + 2) / 2;
  localparam int CNT_W       = $clog2(DIV_STEPS + 1);
  localparam int ROOT_W      = ROOT_STEPS;
  localparam int RAD_W       = 2 * ROOT_STEPS;
  localparam int REM_W       = ROOT_W + 1;

  typedef logic [DATA_W-1:0]      data_t;
  typedef logic [TOTAL_WIDTH-1:0] total_t;
  typedef logic [PROD_W-1:0]      prod_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_LAT,
    S_LAT_FIN,
    S_TRL,
    S_TRL_FIN,
    S_TRA,
    S_TRA_FIN,
    S_CURV,
    S_FIN
  } state_t;

  // saturating add of a wide increment into a running total
  function automatic total_t sat_add(total_t acc, prod_t inc);
    logic [TOTAL_WIDTH:0] sum;
    total_t               inc_c;
    begin
      if (|inc[PROD_W-1:TOTAL_WIDTH]) begin
        inc_c = '1;
      end else begin
        inc_c = inc[TOTAL_WIDTH-1:0];
      end
      sum = {1'b0, acc} + {1'b0, inc_c};
      if (sum[TOTAL_WIDTH]) begin
        sat_add = '1;
      end else begin
        sat_add = sum[TOTAL_WIDTH-1:0];
      end
    end
  endfunction

  // magnitude of a signed 32-bit word as unsigned
  function automatic data_t mag(data_t v);
    begin
      if (v[DATA_W-1]) begin
        mag = ~v + data_t'(1);
      end else begin
        mag = v;
      end
    end
  endfunction

endpackage

@@ rtl/tma_in_if.sv @@
// ----------------------------------------------------------------------------
// tma_in_if
// Sample channel: one odometry and IMU item per handshake.
// ----------------------------------------------------------------------------
interface tma_in_if;
  logic          valid;
  logic          ready;
  tma_pkg::data_t pos_x;
  tma_pkg::data_t pos_y;
  tma_pkg::data_t pos_z;
  tma_pkg::data_t lin_velocity;
  tma_pkg::data_t yaw_rate;
  tma_pkg::data_t fwd_accel;
  tma_pkg::data_t elapsed_time;

  modport source (
    output valid, pos_x, pos_y, pos_z, lin_velocity, yaw_rate, fwd_accel,
    elapsed_time,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, lin_velocity, yaw_rate, fwd_accel,
    elapsed_time,
    output ready
  );
endinterface

@@ rtl/tma_out_if.sv @@
// ----------------------------------------------------------------------------
// tma_out_if
// Totals channel: the four running metrics, one item per sample.
// ----------------------------------------------------------------------------
interface tma_out_if;
  logic            valid;
  logic            ready;
  tma_pkg::total_t path_length;
  tma_pkg::total_t curvature_change_total;
  tma_pkg::total_t lateral_stress_total;
  tma_pkg::total_t tangential_stress_total;

  modport source (
    output valid, path_length, curvature_change_total, lateral_stress_total,
    tangential_stress_total,
    input  ready
  );
  modport sink (
    input  valid, path_length, curvature_change_total, lateral_stress_total,
    tangential_stress_total,
    output ready
  );
endinterface

@@ rtl/trajectory_metric_accumulator.sv @@
// ----------------------------------------------------------------------------
// trajectory_metric_accumulator
// Running path length, curvature change and stress integrals per sample.
// ----------------------------------------------------------------------------
// Usage:
//   sample : sink channel, one odometry/IMU item (Q16.16 fields).
//   totals : source channel, the four saturating Q32.16 totals after
//            each sample; exactly one totals item per sample item.
// Sequencing:
//   A new sample is taken only once the totals of the last one have
//   gone to the output register. The shared bit-serial multiplier runs
//   three 33-step squares, then the 34-step square root, then the
//   lateral product and two trapezoid products (33 steps each, each
//   followed by its own finish state).
//   The 48-step divider for curvature runs alongside the squares.
//   sample.ready is high only between items.
// Reset:
//   rst (synchronous) clears the previous position, the previous
//   curvature and stress values and all four totals.
// Stall:
//   The totals item sits in an output register, so the next sample is
//   taken while it waits; the block holds its finished item before
//   the output register only if that register is still full.
// ----------------------------------------------------------------------------
module trajectory_metric_accumulator (
  input logic       clk,
  input logic       rst,
  tma_in_if.sink    sample,
  tma_out_if.source totals
);

  localparam int DW  = tma_pkg::DATA_W;
  localparam int PW  = tma_pkg::PROD_W;
  localparam int FB  = tma_pkg::FRAC_BITS;
  localparam int CW  = tma_pkg::CNT_W;
  localparam int RW  = tma_pkg::ROOT_W;
  localparam int XW  = tma_pkg::REM_W;
  localparam int AW  = tma_pkg::RAD_W;
  localparam int QW  = tma_pkg::DIV_STEPS;

  localparam logic [CW-1:0] MUL_LAST  = CW'(tma_pkg::MUL_STEPS - 1);
  localparam logic [CW-1:0] ROOT_LAST = CW'(tma_pkg::ROOT_STEPS - 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(tma_pkg::DIV_STEPS - 1);

  tma_pkg::state_t state, state_next;

  // architectural state
  tma_pkg::data_t  prev_position [3];
  tma_pkg::data_t  prev_curvature;
  tma_pkg::data_t  prev_lateral_stress;
  tma_pkg::data_t  prev_accel_magnitude;
  tma_pkg::total_t sum_path;
  tma_pkg::total_t sum_curvature;
  tma_pkg::total_t sum_lateral;
  tma_pkg::total_t sum_tangential;

  // captured item
  tma_pkg::data_t  dmag [3];
  tma_pkg::data_t  vel_m;
  tma_pkg::data_t  yaw_m;
  tma_pkg::data_t  acc_m;
  tma_pkg::data_t  t_val;
  tma_pkg::data_t  lat_now;
  logic            vel_nz;

  // serial multiplier
  tma_pkg::prod_t  prod;
  tma_pkg::prod_t  mcand;
  logic [DW:0]     mplier;
  logic [CW-1:0]   cnt;
  logic [1:0]      sq_idx;
  logic [1:0]      sq_idx_nxt;

  // serial square root
  logic [AW-1:0]   rad;
  logic [XW-1:0]   root_rem;
  logic [RW-1:0]   root;
  logic [XW+1:0]   root_sh;
  logic [XW+1:0]   root_trial;
  logic            root_ge;

  // serial divider
  logic [QW-1:0]   dvd;
  tma_pkg::data_t  div_rem;
  logic [DW:0]     div_sh;
  logic            div_ge;
  logic            div_busy;
  logic [CW-1:0]   div_cnt;

  // output register
  logic            out_valid;
  tma_pkg::total_t out_path;
  tma_pkg::total_t out_curv;
  tma_pkg::total_t out_lat;
  tma_pkg::total_t out_tan;

  // control outputs
  logic            accept;
  logic            mul_run;
  logic            cnt_last;
  logic            out_load;

  // combinational helpers
  tma_pkg::data_t  lat_val;
  tma_pkg::data_t  curv_val;
  tma_pkg::data_t  curv_diff;
  logic [DW:0]     d_full [3];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tma_pkg::S_IDLE:    if (sample.valid) state_next = tma_pkg::S_SQ;
      tma_pkg::S_SQ:      if (cnt_last && sq_idx == 2'd2) state_next = tma_pkg::S_ROOT;
      tma_pkg::S_ROOT:    if (cnt_last) state_next = tma_pkg::S_LAT;
      tma_pkg::S_LAT:     if (cnt_last) state_next = tma_pkg::S_LAT_FIN;
      tma_pkg::S_LAT_FIN: state_next = tma_pkg::S_TRL;
      tma_pkg::S_TRL:     if (cnt_last) state_next = tma_pkg::S_TRL_FIN;
      tma_pkg::S_TRL_FIN: state_next = tma_pkg::S_TRA;
      tma_pkg::S_TRA:     if (cnt_last) state_next = tma_pkg::S_TRA_FIN;
      tma_pkg::S_TRA_FIN: state_next = tma_pkg::S_CURV;
      tma_pkg::S_CURV:    if (!div_busy) state_next = tma_pkg::S_FIN;
      tma_pkg::S_FIN:     if (!out_valid || totals.ready) state_next = tma_pkg::S_IDLE;
      default:            state_next = tma_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    sample.ready = 1'b0;
    mul_run      = 1'b0;
    cnt_last     = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      tma_pkg::S_IDLE: sample.ready = 1'b1;
      tma_pkg::S_SQ, tma_pkg::S_LAT, tma_pkg::S_TRL, tma_pkg::S_TRA: begin
        mul_run  = 1'b1;
        cnt_last = (cnt == MUL_LAST);
      end
      tma_pkg::S_ROOT: cnt_last = (cnt == ROOT_LAST);
      tma_pkg::S_FIN:  out_load = !out_valid || totals.ready;
      default: ;
    endcase
  end

  assign accept = sample.valid && sample.ready;

  // position differences at acceptance
  always_comb begin
    d_full[0] = {sample.pos_x[DW-1], sample.pos_x} -
                {prev_position[0][DW-1], prev_position[0]};
    d_full[1] = {sample.pos_y[DW-1], sample.pos_y} -
                {prev_position[1][DW-1], prev_position[1]};
    d_full[2] = {sample.pos_z[DW-1], sample.pos_z} -
                {prev_position[2][DW-1], prev_position[2]};
  end

  assign sq_idx_nxt = sq_idx + 2'd1;

  // root step
  assign root_sh    = {root_rem, rad[AW-1 -: 2]};
  assign root_trial = {1'b0, root, 2'b01};
  assign root_ge    = (root_sh >= root_trial);

  // divider step
  assign div_sh = {div_rem, dvd[QW-1]};
  assign div_ge = (div_sh >= {1'b0, vel_m});

  // lateral stress from the finished product, saturated
  assign lat_val = (|prod[PW-1:FB+DW]) ? '1 : prod[FB +: DW];

  // curvature from the quotient, saturated
  assign curv_val  = (|dvd[QW-1:DW]) ? '1 : dvd[DW-1:0];
  assign curv_diff = (curv_val >= prev_curvature) ? curv_val - prev_curvature
                                                  : prev_curvature - curv_val;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tma_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // multiplier and sequencer datapath
  always_ff @(posedge clk) begin
    if (mul_run) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= {mcand[PW-2:0], 1'b0};
      mplier <= {1'b0, mplier[DW:1]};
    end
    if (mul_run || state == tma_pkg::S_ROOT) begin
      cnt <= cnt_last ? '0 : cnt + CW'(1);
    end

    // capture item and start the first square
    if (accept) begin
      dmag[0] <= d_full[0][DW] ? DW'(-d_full[0]) : d_full[0][DW-1:0];
      dmag[1] <= d_full[1][DW] ? DW'(-d_full[1]) : d_full[1][DW-1:0];
      dmag[2] <= d_full[2][DW] ? DW'(-d_full[2]) : d_full[2][DW-1:0];
      vel_m   <= tma_pkg::mag(sample.lin_velocity);
      yaw_m   <= tma_pkg::mag(sample.yaw_rate);
      acc_m   <= tma_pkg::mag(sample.fwd_accel);
      t_val   <= sample.elapsed_time;
      vel_nz  <= |sample.lin_velocity;
      prod    <= '0;
      mcand   <= PW'(d_full[0][DW] ? DW'(-d_full[0]) : d_full[0][DW-1:0]);
      mplier  <= {1'b0, (d_full[0][DW] ? DW'(-d_full[0]) : d_full[0][DW-1:0])};
      cnt     <= '0;
      sq_idx  <= 2'd0;
    end

    // next square, or hand the sum to the root
    if (state == tma_pkg::S_SQ && cnt_last) begin
      if (sq_idx == 2'd2) begin
        rad      <= {{(AW-PW){1'b0}}, prod + (mplier[0] ? mcand : '0)};
        root_rem <= '0;
        root     <= '0;
      end else begin
        sq_idx <= sq_idx_nxt;
        mcand  <= PW'(dmag[sq_idx_nxt]);
        mplier <= {1'b0, dmag[sq_idx_nxt]};
      end
    end

    if (state == tma_pkg::S_ROOT) begin
      rad      <= {rad[AW-3:0], 2'b00};
      root_rem <= root_ge ? XW'(root_sh - root_trial) : XW'(root_sh);
      root     <= {root[RW-2:0], root_ge};
      if (cnt_last) begin
        prod   <= '0;
        mcand  <= PW'(yaw_m);
        mplier <= {1'b0, vel_m};
      end
    end

    // lateral product done: start its trapezoid
    if (state == tma_pkg::S_LAT_FIN) begin
      lat_now <= lat_val;
      prod    <= '0;
      mcand   <= PW'({1'b0, lat_val} + {1'b0, prev_lateral_stress});
      mplier  <= {1'b0, t_val};
      cnt     <= '0;
    end

    // acceleration trapezoid
    if (state == tma_pkg::S_TRL_FIN) begin
      prod   <= '0;
      mcand  <= PW'({1'b0, acc_m} + {1'b0, prev_accel_magnitude});
      mplier <= {1'b0, t_val};
      cnt    <= '0;
    end
  end

  // divider: runs alongside the squares
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (accept) begin
      div_busy <= |sample.lin_velocity;
    end else if (div_busy && div_cnt == DIV_LAST) begin
      div_busy <= 1'b0;
    end
    if (accept) begin
      dvd     <= {tma_pkg::mag(sample.yaw_rate), {FB{1'b0}}};
      div_rem <= '0;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_rem <= div_ge ? DW'(div_sh - {1'b0, vel_m}) : div_sh[DW-1:0];
      dvd     <= {dvd[QW-2:0], div_ge};
      div_cnt <= div_cnt + CW'(1);
    end
  end

  // architectural state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_position[0]     <= '0;
      prev_position[1]     <= '0;
      prev_position[2]     <= '0;
      prev_curvature       <= '0;
      prev_lateral_stress  <= '0;
      prev_accel_magnitude <= '0;
      sum_path             <= '0;
      sum_curvature        <= '0;
      sum_lateral          <= '0;
      sum_tangential       <= '0;
    end else begin
      if (accept) begin
        prev_position[0] <= sample.pos_x;
        prev_position[1] <= sample.pos_y;
        prev_position[2] <= sample.pos_z;
      end
      if (state == tma_pkg::S_LAT && cnt == '0) begin
        sum_path <= tma_pkg::sat_add(sum_path, PW'(root));
      end
      if (state == tma_pkg::S_TRL_FIN) begin
        sum_lateral         <= tma_pkg::sat_add(sum_lateral, prod >> (FB + 1));
        prev_lateral_stress <= lat_now;
      end
      if (state == tma_pkg::S_TRA_FIN) begin
        sum_tangential       <= tma_pkg::sat_add(sum_tangential, prod >> (FB + 1));
        prev_accel_magnitude <= acc_m;
      end
      if (state == tma_pkg::S_CURV && !div_busy && vel_nz) begin
        sum_curvature  <= tma_pkg::sat_add(sum_curvature, PW'(curv_diff));
        prev_curvature <= curv_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (totals.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_path <= sum_path;
      out_curv <= sum_curvature;
      out_lat  <= sum_lateral;
      out_tan  <= sum_tangential;
    end
  end

  assign totals.valid                   = out_valid;
  assign totals.path_length             = out_path;
  assign totals.curvature_change_total  = out_curv;
  assign totals.lateral_stress_total    = out_lat;
  assign totals.tangential_stress_total = out_tan;

  // checks
  a_path_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> sum_path >= $past(sum_path))
    else $error("path length decreased");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == tma_pkg::S_SQ)
    else $error("accepted item did not start the squares");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == tma_pkg::S_FIN)
    else $error("totals item raised outside the finish state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == tma_pkg::S_FIN |-> !div_busy)
    else $error("divider still busy at finish");

endmodule

@@ verif/tma_checker.sv @@
// ----------------------------------------------------------------------------
// tma_checker
// Watches the sample and totals channels, predicts the four running totals
// for every accepted sample and compares them with each totals item.
// ----------------------------------------------------------------------------
module tma_checker (
  input  logic       clk,
  input  logic       rst,
  tma_in_if          sample,
  tma_out_if         totals,
  output int         fail_count,
  output int         pending_totals,
  output int         totals_seen
);

  localparam logic [63:0] TOT_MAX = (64'd1 << tma_pkg::TOTAL_WIDTH) - 1;
  localparam logic [63:0] W32_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    tma_pkg::total_t path;
    tma_pkg::total_t curv;
    tma_pkg::total_t lat;
    tma_pkg::total_t tang;
  } metrics_t;

  // predictor state
  logic signed [63:0] last_pos [3];
  logic [63:0] last_curv, last_lat, last_acc;
  logic [63:0] run_path, run_curv, run_lat, run_tang;
  metrics_t    expected_totals [$];

  function automatic logic [63:0] clip_add(logic [63:0] a, logic [127:0] b);
    logic [127:0] s;
    s = 128'(a) + b;
    return (s > 128'(TOT_MAX)) ? TOT_MAX : s[63:0];
  endfunction

  function automatic logic [63:0] abs32(tma_pkg::data_t v);
    tma_pkg::data_t m;
    m = v[31] ? (~v + 32'd1) : v;
    return {32'd0, m};
  endfunction

  // floor of the square root of a wide radicand
  function automatic logic [63:0] floor_root(logic [127:0] r);
    logic [127:0] root, rem, trial;
    root = 0;
    rem = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | ((r >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  // trapezoid area: (a + b) * t / 2^(FRAC_BITS+1), truncated
  function automatic logic [127:0] trap_area(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] t);
    logic [127:0] p;
    p = 128'(a + b) * 128'(t);
    return p >> (tma_pkg::FRAC_BITS + 1);
  endfunction

  task automatic predict_totals();
    logic [127:0] radicand, d;
    logic signed [63:0] p, diff;
    logic [63:0] vel, yaw, acc, t, c, lat, dc;
    metrics_t m;
    radicand = 0;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: p = 64'(signed'(sample.pos_x));
        1: p = 64'(signed'(sample.pos_y));
        default: p = 64'(signed'(sample.pos_z));
      endcase
      diff = p - last_pos[i];
      d = 128'(diff < 0 ? -diff : diff);
      radicand += d * d;
      last_pos[i] = p;
    end
    run_path = clip_add(run_path, 128'(floor_root(radicand)));
    vel = abs32(sample.lin_velocity);
    yaw = abs32(sample.yaw_rate);
    acc = abs32(sample.fwd_accel);
    t = 64'(sample.elapsed_time);
    // curvature skipped at standstill
    if (vel != 0) begin
      c = (yaw << tma_pkg::FRAC_BITS) / vel;
      if (c > W32_MAX) c = W32_MAX;
      dc = (c >= last_curv) ? c - last_curv : last_curv - c;
      run_curv = clip_add(run_curv, 128'(dc));
      last_curv = c;
    end
    lat = (yaw * vel) >> tma_pkg::FRAC_BITS;
    if (lat > W32_MAX) lat = W32_MAX;
    run_lat = clip_add(run_lat, trap_area(lat, last_lat, t));
    last_lat = lat;
    run_tang = clip_add(run_tang, trap_area(acc, last_acc, t));
    last_acc = acc;
    m.path = run_path[tma_pkg::TOTAL_WIDTH-1:0];
    m.curv = run_curv[tma_pkg::TOTAL_WIDTH-1:0];
    m.lat  = run_lat[tma_pkg::TOTAL_WIDTH-1:0];
    m.tang = run_tang[tma_pkg::TOTAL_WIDTH-1:0];
    expected_totals.push_back(m);
  endtask

  assign pending_totals = expected_totals.size();

  always @(posedge clk) begin
    metrics_t e;
    if (rst) begin
      for (int i = 0; i < 3; i++) last_pos[i] = 0;
      last_curv = 0; last_lat = 0; last_acc = 0;
      run_path = 0; run_curv = 0; run_lat = 0; run_tang = 0;
      expected_totals.delete();
      fail_count <= 0;
      totals_seen <= 0;
    end else begin
      // compare first: queue holds only earlier samples
      if (totals.valid && totals.ready) begin
        totals_seen <= totals_seen + 1;
        if (expected_totals.size() == 0) begin
          if (fail_count < 10) $display("ERROR: totals item with none expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_totals.pop_front();
          if (e.path != totals.path_length || e.curv != totals.curvature_change_total ||
              e.lat != totals.lateral_stress_total ||
              e.tang != totals.tangential_stress_total) begin
            if (fail_count < 10)
              $display("ERROR: totals exp %h %h %h %h got %h %h %h %h",
                       e.path, e.curv, e.lat, e.tang, totals.path_length,
                       totals.curvature_change_total, totals.lateral_stress_total,
                       totals.tangential_stress_total);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (sample.valid && sample.ready) predict_totals();
    end
  end
endmodule

@@ verif/tb_trajectory_metric_accumulator.sv @@
// ----------------------------------------------------------------------------
// tb_trajectory_metric_accumulator
// Drives directed and random odometry samples with random gaps and stalls;
// the checker predicts every totals item and counts mismatches.
// ----------------------------------------------------------------------------
module tb_trajectory_metric_accumulator;

  localparam int RANDOM_ITEMS = 930;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LATENCY      = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_totals, totals_seen;
  int   cycle_count = 0;
  int   items_sent = 0;
  bit   long_stall = 1'b0;

  tma_in_if  sample ();
  tma_out_if totals ();

  trajectory_metric_accumulator dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample.sink),
    .totals (totals.source)
  );

  tma_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample),
    .totals         (totals),
    .fail_count     (fail_count),
    .pending_totals (pending_totals),
    .totals_seen    (totals_seen)
  );

  always #5 clk = ~clk;

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL trajectory_metric_accumulator");
      $finish;
    end
  end

  // receiver: random stalls per item, one long hold-off
  initial begin
    int wait_cycles;
    totals.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_stall) begin
        totals.ready <= 1'b0;
        repeat (2000) @(posedge clk);
        long_stall = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (wait_cycles > 0) begin
        totals.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      totals.ready <= 1'b1;
      @(posedge clk);
      while (!totals.valid) @(posedge clk);
    end
  end

  function automatic tma_pkg::data_t edgy_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return tma_pkg::data_t'($urandom_range(0, 32'h0003_FFFF)) - 32'h0001_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // valid stays high after the handshake until the next gap or a drain
  task automatic send_sample(tma_pkg::data_t x, tma_pkg::data_t y, tma_pkg::data_t z,
                             tma_pkg::data_t v, tma_pkg::data_t w,
                             tma_pkg::data_t a, tma_pkg::data_t t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.pos_x <= x; sample.pos_y <= y; sample.pos_z <= z;
    sample.lin_velocity <= v; sample.yaw_rate <= w;
    sample.fwd_accel <= a; sample.elapsed_time <= t;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (pending_totals != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    tma_pkg::data_t px, py, pz;
    sample.valid = 1'b0;
    sample.pos_x = '0; sample.pos_y = '0; sample.pos_z = '0;
    sample.lin_velocity = '0; sample.yaw_rate = '0;
    sample.fwd_accel = '0; sample.elapsed_time = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first sample from origin, zero velocity, extremes
    send_sample(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 0, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000);
    send_sample(0, 0, 0, 0, 0, 0, 0);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 0, 32'h0000_0001, 32'hFFFF_0000, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'h0000_0001);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(0, 0, 0, 32'h0000_0001, 0, 0, 0);
    // saturation run: twelve huge swings that pin the stress totals at maximum
    for (int i = 0; i < 12; i++)
      send_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, i[0] ? 32'h0000_0001 : 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    drain();

    // random: mostly smooth trajectories, some wild samples
    px = 0; py = 0; pz = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) long_stall = 1'b1;
      if (i == 600) drain();
      if ($urandom_range(0, 4) != 0) begin
        px += tma_pkg::data_t'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        py += tma_pkg::data_t'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        pz += tma_pkg::data_t'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000;
        send_sample(px, py, pz,
                    ($urandom_range(0, 9) == 0) ? 32'h0 :
                      tma_pkg::data_t'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000,
                    tma_pkg::data_t'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000,
                    tma_pkg::data_t'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000,
                    $urandom_range(0, 32'h0000_2000));
      end else begin
        px = edgy_word(); py = edgy_word(); pz = edgy_word();
        send_sample(px, py, pz, edgy_word(), edgy_word(), edgy_word(), edgy_word());
      end
    end

    drain();
    $display("Covered %0d samples (directed extremes, saturation, smooth and wild paths)",
             items_sent);
    $display("Checked %0d totals items with random gaps, stalls and a long hold-off",
             totals_seen);
    if (fail_count == 0) begin
      $display("PASS trajectory_metric_accumulator");
    end else begin
      $display("FAIL trajectory_metric_accumulator");
    end
    $finish;
  end
endmodule
